// ===== hdl/nec_ir_edge_decoder_macros.svh =====
// Assertion macros used by the bound checker of the IR decoder.
`ifndef NEC_IR_EDGE_DECODER_MACROS_SVH
`define NEC_IR_EDGE_DECODER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define NIRDEC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nec_ir_edge_decoder: assertion failed");

// Next-cycle implication, switched off while reset is held.
`define NIRDEC_ASSERT_NEXT(label, clk, ante, cons, rst_n) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nec_ir_edge_decoder: assertion failed");

// Next-cycle implication that stays active through reset.
`define NIRDEC_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("nec_ir_edge_decoder: reset assertion failed");

`endif

// ===== hdl/nirdec_pkg.sv =====
package nirdec_pkg;

    // Item kinds carried in the input tuser.
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes.
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_HOLD_TIME     = 2'd0;
    localparam t_reg_idx REG_FRAME_GAP     = 2'd1;
    localparam t_reg_idx REG_LEAD_MARK_MIN = 2'd2;
    localparam t_reg_idx REG_LEAD_MARK_MAX = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] HOLD_TIME_RST     = 16'd400;
    localparam logic [15:0] FRAME_GAP_RST     = 16'd15000;
    localparam logic [15:0] LEAD_MARK_MIN_RST = 16'd6800;
    localparam logic [15:0] LEAD_MARK_MAX_RST = 16'd11200;

    // Fixed timing windows and thresholds in microseconds, and the byte check sum.
    localparam logic [15:0] SHORT_LEAD_MIN  = 16'd200;
    localparam logic [15:0] SHORT_LEAD_MAX  = 16'd1200;
    localparam logic [15:0] REPEAT_MIN      = 16'd1200;
    localparam logic [15:0] REPEAT_MAX      = 16'd3200;
    localparam logic [15:0] DATA_SPACE_MIN  = 16'd3200;
    localparam logic [15:0] DATA_SPACE_MAX  = 16'd6200;
    localparam logic [15:0] BIT_MARK_MIN    = 16'd150;
    localparam logic [15:0] BIT_MARK_MAX    = 16'd1200;
    localparam logic [15:0] ZERO_SPACE_MIN  = 16'd100;
    localparam logic [15:0] ZERO_SPACE_MAX  = 16'd1000;
    localparam logic [15:0] ONE_SPACE_MIN   = 16'd1100;
    localparam logic [15:0] ONE_SPACE_MAX   = 16'd2500;
    localparam logic [15:0] IDLE_ARM_GAP    = 16'd3000;
    localparam logic [7:0]  BYTE_COMPLEMENT = 8'hFF;

    // Key command bytes.
    localparam logic [7:0] KEY_UP    = 8'h52;
    localparam logic [7:0] KEY_DOWN  = 8'h18;
    localparam logic [7:0] KEY_LEFT  = 8'h5A;
    localparam logic [7:0] KEY_RIGHT = 8'h08;
    localparam logic [7:0] KEY_OK    = 8'h1C;

    // Motion commands.
    typedef logic [2:0] t_motion;
    localparam t_motion MOTION_STOP     = 3'd0;
    localparam t_motion MOTION_FORWARD  = 3'd1;
    localparam t_motion MOTION_BACKWARD = 3'd2;
    localparam t_motion MOTION_LEFT     = 3'd3;
    localparam t_motion MOTION_RIGHT    = 3'd4;

    // Failure codes.
    typedef logic [3:0] t_fail;
    localparam t_fail FAIL_OK         = 4'd0;
    localparam t_fail FAIL_STRAY_EDGE = 4'd1;
    localparam t_fail FAIL_LEAD_MARK  = 4'd2;
    localparam t_fail FAIL_LEAD_SPACE = 4'd3;
    localparam t_fail FAIL_BIT_MARK   = 4'd4;
    localparam t_fail FAIL_BIT_SPACE  = 4'd5;
    localparam t_fail FAIL_CMD_CHECK  = 4'd6;
    localparam t_fail FAIL_ADDR_CHECK = 4'd7;
    localparam t_fail FAIL_UNKNOWN    = 4'd8;

    // Receiver phases.
    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_LEAD_RISE = 5'b00010,
        PH_LEAD_FALL = 5'b00100,
        PH_BIT_RISE  = 5'b01000,
        PH_BIT_FALL  = 5'b10000
    } t_phase;

    // Input and result packing widths.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 80;

    typedef struct packed {
        logic        operation;
        logic [15:0] edge_time_us;
        logic        pin_level;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        t_motion     motion_cmd;
        logic        key_applied;
        logic [7:0]  last_code;
        t_fail       fail_code;
        logic [31:0] edge_total;
        logic [15:0] lead_mark_us;
        logic [15:0] lead_space_us;
    } t_result;

    typedef struct packed {
        logic [15:0] hold_time_ms;
        logic [15:0] frame_gap_us;
        logic [15:0] lead_mark_min_us;
        logic [15:0] lead_mark_max_us;
    } t_cfg;

    typedef struct packed {
        logic    hit;
        t_motion motion;
    } t_key_lookup;

    // Maps a command byte to its motion command.
    function automatic t_key_lookup key_motion(input logic [7:0] k);
        t_key_lookup r;
        r.hit    = 1'b1;
        r.motion = MOTION_STOP;
        case (k)
            KEY_UP:    r.motion = MOTION_FORWARD;
            KEY_DOWN:  r.motion = MOTION_BACKWARD;
            KEY_LEFT:  r.motion = MOTION_LEFT;
            KEY_RIGHT: r.motion = MOTION_RIGHT;
            KEY_OK:    r.motion = MOTION_STOP;
            default:   r.hit    = 1'b0;
        endcase
        return r;
    endfunction

    // Bit reversal of one byte.
    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

endpackage

// ===== hdl/nec_ir_edge_decoder.sv =====
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: edge, level, ms; tuser: kind
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: one result per item
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One item per clock sustained unless the result stalls; a result beat is registered.
// The decode is a single pass from the input register through the edge sequencer
// to the result register; the sequencer state updates once per item.
// Reset is synchronous and active low; it clears the decoder state and loads the
// configuration defaults. A stalled result stalls the input register, which then
// stalls the input channel. Configuration writes are taken in every cycle.
module nec_ir_edge_decoder
    import nirdec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] edge_time_us, [16] pin_level, [48:17] now_ms, [55:49] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [2:0] motion_cmd, [3] key_applied, [11:4] last_code, [15:12] fail_code,
    // [47:16] edge_total, [63:48] lead_mark_us, [79:64] lead_space_us
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  t_reg_idx               i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    logic    w_in_valid;
    t_item   w_item;
    logic    w_adv;
    t_cfg    w_cfg;
    t_result w_result;

    // An item moves on when the result register is free or being emptied.
    assign w_adv       = w_in_valid && (!m_axis_tvalid || m_axis_tready);
    assign o_cfg_ready = 1'b1;

    nirdec_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_kind  (s_axis_tuser[0]),
        .i_adv   (w_adv),
        .o_ready (s_axis_tready),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    nirdec_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    nirdec_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (w_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    nirdec_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv),
        .i_result (w_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_data   (m_axis_tdata)
    );

endmodule

// ===== hdl/nirdec_in_stage.sv =====
module nirdec_in_stage
    import nirdec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [IN_TDATA_W-1:0] i_data,
    input  logic                  i_kind,
    input  logic                  i_adv,
    output logic                  o_ready,
    output logic                  o_valid,
    output t_item                 o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // The stage refills in the same cycle that the core takes its item.
    assign o_ready = !r_valid || i_adv;
    assign w_load  = i_valid && o_ready;

    // Valid flag of the held beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    // Unpack the beat into item fields.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.operation    <= i_kind;
            r_item.edge_time_us <= i_data[15:0];
            r_item.pin_level    <= i_data[16];
            r_item.now_ms       <= i_data[48:17];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hdl/nirdec_cfg_regs.sv =====
module nirdec_cfg_regs
    import nirdec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  t_reg_idx    i_index,
    input  logic [15:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Register file, written one register per beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_time_ms     <= HOLD_TIME_RST;
            r_cfg.frame_gap_us     <= FRAME_GAP_RST;
            r_cfg.lead_mark_min_us <= LEAD_MARK_MIN_RST;
            r_cfg.lead_mark_max_us <= LEAD_MARK_MAX_RST;
        end else if (i_wr) begin
            case (i_index)
                REG_HOLD_TIME:     r_cfg.hold_time_ms     <= i_data;
                REG_FRAME_GAP:     r_cfg.frame_gap_us     <= i_data;
                REG_LEAD_MARK_MIN: r_cfg.lead_mark_min_us <= i_data;
                REG_LEAD_MARK_MAX: r_cfg.lead_mark_max_us <= i_data;
                default:           r_cfg                  <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/nirdec_core.sv =====
module nirdec_core
    import nirdec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase      r_phase,        n_phase;
    logic [31:0] r_shift_bits,   n_shift_bits;
    logic [4:0]  r_bit_count,    n_bit_count;
    logic [15:0] r_prev_edge_us, n_prev_edge_us;
    logic [7:0]  r_saved_code,   n_saved_code;
    t_motion     r_held_cmd,     n_held_cmd;
    logic [31:0] r_key_time_ms,  n_key_time_ms;
    logic [31:0] r_edge_counter, n_edge_counter;
    logic [15:0] r_mark_len,     n_mark_len;
    logic [15:0] r_space_len,    n_space_len;
    t_fail       r_fail_reg,     n_fail_reg;

    logic [15:0] w_gap;
    logic        w_one_bit;
    logic [31:0] w_shift_set;
    logic [7:0]  w_cand [4];
    t_key_lookup w_look [4];
    t_key_lookup w_saved_look;
    logic        w_frame_hit;
    logic [7:0]  w_frame_code;
    t_motion     w_frame_motion;
    t_fail       w_frame_fail;
    logic [31:0] w_since_key;
    logic        w_applied;

    // Edge gap modulo 2^16 and the data word with this bit taken in.
    assign w_gap       = i_item.edge_time_us - r_prev_edge_us;
    assign w_one_bit   = w_gap inside {[ONE_SPACE_MIN:ONE_SPACE_MAX]};
    assign w_shift_set = r_shift_bits | ({31'd0, w_one_bit} << r_bit_count);

    // Frame candidates: command, reversed command, inverse, reversed inverse.
    assign w_cand[0] = w_shift_set[23:16];
    assign w_cand[1] = rev8(w_shift_set[23:16]);
    assign w_cand[2] = w_shift_set[31:24];
    assign w_cand[3] = rev8(w_shift_set[31:24]);

    for (genvar g = 0; g < 4; g++) begin : g_look
        assign w_look[g] = key_motion(w_cand[g]);
    end

    assign w_saved_look = key_motion(r_saved_code);

    // First matching candidate wins; otherwise classify the failure.
    always_comb begin
        w_frame_hit    = 1'b1;
        w_frame_code   = w_cand[0];
        w_frame_motion = w_look[0].motion;
        w_frame_fail   = FAIL_OK;
        if (w_look[0].hit) begin
            w_frame_code   = w_cand[0];
            w_frame_motion = w_look[0].motion;
        end else if (w_look[1].hit) begin
            w_frame_code   = w_cand[1];
            w_frame_motion = w_look[1].motion;
        end else if (w_look[2].hit) begin
            w_frame_code   = w_cand[2];
            w_frame_motion = w_look[2].motion;
        end else if (w_look[3].hit) begin
            w_frame_code   = w_cand[3];
            w_frame_motion = w_look[3].motion;
        end else begin
            w_frame_hit = 1'b0;
            if ((w_shift_set[7:0] + w_shift_set[15:8]) != BYTE_COMPLEMENT) begin
                w_frame_fail = FAIL_ADDR_CHECK;
            end else if ((w_shift_set[23:16] + w_shift_set[31:24]) != BYTE_COMPLEMENT) begin
                w_frame_fail = FAIL_CMD_CHECK;
            end else begin
                w_frame_fail = FAIL_UNKNOWN;
            end
        end
    end

    // Receiver sequencing for one edge.
    always_comb begin
        t_phase ph;
        n_phase        = r_phase;
        n_shift_bits   = r_shift_bits;
        n_bit_count    = r_bit_count;
        n_prev_edge_us = r_prev_edge_us;
        n_saved_code   = r_saved_code;
        n_held_cmd     = r_held_cmd;
        n_key_time_ms  = r_key_time_ms;
        n_edge_counter = r_edge_counter;
        n_mark_len     = r_mark_len;
        n_space_len    = r_space_len;
        n_fail_reg     = r_fail_reg;
        w_applied      = 1'b0;
        ph             = r_phase;

        if (i_item.operation == OP_EDGE) begin
            n_prev_edge_us = i_item.edge_time_us;
            n_edge_counter = r_edge_counter + 32'd1;

            // A long gap restarts the decoder before the edge is handled.
            if (w_gap > i_cfg.frame_gap_us) begin
                ph           = PH_IDLE;
                n_phase      = PH_IDLE;
                n_shift_bits = '0;
                n_bit_count  = '0;
                n_fail_reg   = FAIL_OK;
            end

            if (!i_item.pin_level) begin
                case (ph)
                    PH_LEAD_FALL: begin
                        n_space_len = w_gap;
                        if (w_gap inside {[REPEAT_MIN:REPEAT_MAX]}) begin
                            // Repeat frame: reapply the saved code.
                            if (r_saved_code != 8'd0 && w_saved_look.hit) begin
                                n_held_cmd    = w_saved_look.motion;
                                n_key_time_ms = i_item.now_ms;
                                w_applied     = 1'b1;
                            end
                            n_fail_reg   = FAIL_OK;
                            n_phase      = PH_IDLE;
                            n_shift_bits = '0;
                            n_bit_count  = '0;
                        end else if (w_gap inside {[DATA_SPACE_MIN:DATA_SPACE_MAX]}) begin
                            n_shift_bits = '0;
                            n_bit_count  = '0;
                            n_phase      = PH_BIT_RISE;
                        end else begin
                            n_fail_reg   = FAIL_LEAD_SPACE;
                            n_phase      = PH_IDLE;
                            n_shift_bits = '0;
                            n_bit_count  = '0;
                        end
                    end
                    PH_BIT_FALL: begin
                        if (!w_one_bit && !(w_gap inside {[ZERO_SPACE_MIN:ZERO_SPACE_MAX]})) begin
                            n_fail_reg   = FAIL_BIT_SPACE;
                            n_phase      = PH_IDLE;
                            n_shift_bits = '0;
                            n_bit_count  = '0;
                        end else if (r_bit_count == 5'd31) begin
                            // Last of 32 bits: check the frame.
                            n_phase      = PH_IDLE;
                            n_shift_bits = '0;
                            n_bit_count  = '0;
                            n_fail_reg   = w_frame_fail;
                            n_saved_code = w_frame_code;
                            if (w_frame_hit) begin
                                n_held_cmd    = w_frame_motion;
                                n_key_time_ms = i_item.now_ms;
                                w_applied     = 1'b1;
                            end
                        end else begin
                            n_shift_bits = w_shift_set;
                            n_bit_count  = r_bit_count + 5'd1;
                            n_phase      = PH_BIT_RISE;
                        end
                    end
                    PH_IDLE: begin
                        if (w_gap > IDLE_ARM_GAP) begin
                            n_phase    = PH_LEAD_RISE;
                            n_fail_reg = FAIL_OK;
                        end
                    end
                    default: begin
                        n_fail_reg   = FAIL_STRAY_EDGE;
                        n_phase      = PH_IDLE;
                        n_shift_bits = '0;
                        n_bit_count  = '0;
                    end
                endcase
            end else begin
                case (ph)
                    PH_LEAD_RISE: begin
                        n_mark_len = w_gap;
                        if ((w_gap >= i_cfg.lead_mark_min_us && w_gap <= i_cfg.lead_mark_max_us)
                            || (w_gap inside {[SHORT_LEAD_MIN:SHORT_LEAD_MAX]})) begin
                            n_phase = PH_LEAD_FALL;
                        end else begin
                            n_fail_reg   = FAIL_LEAD_MARK;
                            n_phase      = PH_IDLE;
                            n_shift_bits = '0;
                            n_bit_count  = '0;
                        end
                    end
                    PH_BIT_RISE: begin
                        if (w_gap inside {[BIT_MARK_MIN:BIT_MARK_MAX]}) begin
                            n_phase = PH_BIT_FALL;
                        end else begin
                            n_fail_reg   = FAIL_BIT_MARK;
                            n_phase      = PH_IDLE;
                            n_shift_bits = '0;
                            n_bit_count  = '0;
                        end
                    end
                    PH_IDLE: begin
                        n_phase = ph;
                    end
                    default: begin
                        n_fail_reg   = FAIL_STRAY_EDGE;
                        n_phase      = PH_IDLE;
                        n_shift_bits = '0;
                        n_bit_count  = '0;
                    end
                endcase
            end
        end
    end

    // Decoder state, updated once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_shift_bits   <= '0;
            r_bit_count    <= '0;
            r_prev_edge_us <= '0;
            r_saved_code   <= '0;
            r_held_cmd     <= MOTION_STOP;
            r_key_time_ms  <= '0;
            r_edge_counter <= '0;
            r_mark_len     <= '0;
            r_space_len    <= '0;
            r_fail_reg     <= FAIL_OK;
        end else if (i_adv) begin
            r_phase        <= n_phase;
            r_shift_bits   <= n_shift_bits;
            r_bit_count    <= n_bit_count;
            r_prev_edge_us <= n_prev_edge_us;
            r_saved_code   <= n_saved_code;
            r_held_cmd     <= n_held_cmd;
            r_key_time_ms  <= n_key_time_ms;
            r_edge_counter <= n_edge_counter;
            r_mark_len     <= n_mark_len;
            r_space_len    <= n_space_len;
            r_fail_reg     <= n_fail_reg;
        end
    end

    // Result fields from the updated state; the motion command times out.
    assign w_since_key = i_item.now_ms - n_key_time_ms;

    always_comb begin
        o_result.motion_cmd    = (w_since_key < {16'd0, i_cfg.hold_time_ms}) ?
                                 n_held_cmd : MOTION_STOP;
        o_result.key_applied   = w_applied;
        o_result.last_code     = n_saved_code;
        o_result.fail_code     = n_fail_reg;
        o_result.edge_total    = n_edge_counter;
        o_result.lead_mark_us  = n_mark_len;
        o_result.lead_space_us = n_space_len;
    end

endmodule

// ===== hdl/nirdec_out_stage.sv =====
module nirdec_out_stage
    import nirdec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_result                i_result,
    input  logic                   i_ready,
    output logic                   o_valid,
    output logic [OUT_TDATA_W-1:0] o_data
);

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data;

    // Result beat is held until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Pack the result fields, first field in the lowest bits.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= {i_result.lead_space_us,
                       i_result.lead_mark_us,
                       i_result.edge_total,
                       i_result.fail_code,
                       i_result.last_code,
                       i_result.key_applied,
                       i_result.motion_cmd};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/nirdec_checker.sv =====
`include "nec_ir_edge_decoder_macros.svh"

module nirdec_checker
    import nirdec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A waiting result beat keeps its valid and data.
    `NIRDEC_ASSERT_NEXT(a_out_hold, i_clk, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), i_rst_n)

    // No result beat is offered right after reset.
    `NIRDEC_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)

    // An applied key always comes with a clean status.
    `NIRDEC_ASSERT_SAME(a_key_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[15:12] == FAIL_OK)

    // The failure code stays within its defined codes.
    `NIRDEC_ASSERT_SAME(a_fail_range, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tdata[15] && (m_axis_tdata[14:12] != 3'd0)))

    // An item taken while the result waits leaves the result offered, the sink not ready or input refused.
    `NIRDEC_ASSERT_NEXT(a_in_stall, i_clk, s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready, !m_axis_tready || !s_axis_tready || m_axis_tvalid, i_rst_n)

endmodule

bind nec_ir_edge_decoder nirdec_checker u_nirdec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/nec_ir_edge_decoder_checker.sv =====
// Watches the item, result and register channels of the IR decoder, keeps its
// own model of the decoder state and compares every result beat in order.
module nec_ir_edge_decoder_checker
    import nirdec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic [0:0]             i_in_user,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  t_reg_idx               i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    output int                     o_pending,
    output int                     o_errors
);

    localparam int PRINT_LIMIT = 40;

    // Decoder model state and register copy.
    t_cfg        cfg_q;
    t_phase      rx_ph;
    logic [31:0] bits_q;
    logic [5:0]  nbits;
    logic [15:0] last_edge;
    logic [7:0]  code_q;
    t_motion     held_q;
    logic [31:0] key_ms;
    logic [31:0] edges_q;
    logic [15:0] mark_q;
    logic [15:0] space_q;
    t_fail       fail_q;

    t_result     pending_results[$];
    t_result     want;
    t_result     fresh;
    int          err_count = 0;
    int          result_idx = 0;

    assign o_errors = err_count;

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_LIMIT) begin
            $display("mismatch at result %0d: %s", result_idx, msg);
        end
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
        end
    endtask

    function automatic logic [7:0] flip_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

    // Command byte to motion; hit is low for a byte that is no key.
    function automatic t_key_lookup lookup_key(input logic [7:0] k);
        t_key_lookup r;
        r = '{hit: 1'b0, motion: MOTION_STOP};
        if (k == KEY_UP) r = '{hit: 1'b1, motion: MOTION_FORWARD};
        if (k == KEY_DOWN) r = '{hit: 1'b1, motion: MOTION_BACKWARD};
        if (k == KEY_LEFT) r = '{hit: 1'b1, motion: MOTION_LEFT};
        if (k == KEY_RIGHT) r = '{hit: 1'b1, motion: MOTION_RIGHT};
        if (k == KEY_OK) r = '{hit: 1'b1, motion: MOTION_STOP};
        return r;
    endfunction

    function automatic bit in_window(input logic [15:0] v, input logic [15:0] lo,
                                     input logic [15:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    task automatic drop_frame();
        rx_ph  = PH_IDLE;
        bits_q = '0;
        nbits  = '0;
    endtask

    // Saves the code; a known key also loads the motion command and its time.
    task automatic store_code(input logic [7:0] k, input logic [31:0] now,
                              output logic hit);
        t_key_lookup m;
        m      = lookup_key(k);
        code_q = k;
        hit    = m.hit;
        if (m.hit) begin
            held_q = m.motion;
            key_ms = now;
        end
    endtask

    // End of the 32 data bits: try the four command candidates, then classify.
    task automatic close_frame(input logic [31:0] now, output logic applied);
        logic [7:0]  cand [4];
        logic [7:0]  addr;
        logic [7:0]  addr_cpl;
        logic [7:0]  sum;
        logic        done;
        t_key_lookup m;
        addr     = bits_q[7:0];
        addr_cpl = bits_q[15:8];
        cand[0]  = bits_q[23:16];
        cand[1]  = flip_byte(bits_q[23:16]);
        cand[2]  = bits_q[31:24];
        cand[3]  = flip_byte(bits_q[31:24]);
        code_q   = cand[0];
        drop_frame();
        applied  = 1'b0;
        done     = 1'b0;
        for (int i = 0; i < 4; i++) begin
            m = lookup_key(cand[i]);
            if (!done && m.hit) begin
                fail_q = FAIL_OK;
                store_code(cand[i], now, applied);
                done = 1'b1;
            end
        end
        if (!done) begin
            sum = addr + addr_cpl;
            if (sum != BYTE_COMPLEMENT) begin
                fail_q = FAIL_ADDR_CHECK;
            end else begin
                sum = cand[0] + cand[2];
                fail_q = (sum != BYTE_COMPLEMENT) ? FAIL_CMD_CHECK : FAIL_UNKNOWN;
            end
        end
    endtask

    // One receiver edge through the phase sequence.
    task automatic take_edge(input logic [15:0] t, input logic lvl,
                             input logic [31:0] now, output logic applied);
        logic [15:0] d;
        d         = t - last_edge;
        last_edge = t;
        edges_q   = edges_q + 32'd1;
        applied   = 1'b0;
        if (d > cfg_q.frame_gap_us) begin
            drop_frame();
            fail_q = FAIL_OK;
        end
        if (!lvl) begin
            case (rx_ph)
                PH_LEAD_FALL: begin
                    space_q = d;
                    if (in_window(d, REPEAT_MIN, REPEAT_MAX)) begin
                        if (code_q != 8'h00) store_code(code_q, now, applied);
                        fail_q = FAIL_OK;
                        drop_frame();
                    end else if (!in_window(d, DATA_SPACE_MIN, DATA_SPACE_MAX)) begin
                        fail_q = FAIL_LEAD_SPACE;
                        drop_frame();
                    end else begin
                        bits_q = '0;
                        nbits  = '0;
                        rx_ph  = PH_BIT_RISE;
                    end
                end
                PH_BIT_FALL: begin
                    if (!in_window(d, ONE_SPACE_MIN, ONE_SPACE_MAX) &&
                        !in_window(d, ZERO_SPACE_MIN, ZERO_SPACE_MAX)) begin
                        fail_q = FAIL_BIT_SPACE;
                        drop_frame();
                    end else begin
                        if (in_window(d, ONE_SPACE_MIN, ONE_SPACE_MAX)) begin
                            bits_q[nbits[4:0]] = 1'b1;
                        end
                        nbits = nbits + 6'd1;
                        if (nbits >= 6'd32) begin
                            close_frame(now, applied);
                        end else begin
                            rx_ph = PH_BIT_RISE;
                        end
                    end
                end
                PH_IDLE: begin
                    if (d > IDLE_ARM_GAP) begin
                        rx_ph  = PH_LEAD_RISE;
                        fail_q = FAIL_OK;
                    end
                end
                default: begin
                    fail_q = FAIL_STRAY_EDGE;
                    drop_frame();
                end
            endcase
        end else begin
            case (rx_ph)
                PH_LEAD_RISE: begin
                    mark_q = d;
                    if (in_window(d, cfg_q.lead_mark_min_us, cfg_q.lead_mark_max_us) ||
                        in_window(d, SHORT_LEAD_MIN, SHORT_LEAD_MAX)) begin
                        rx_ph = PH_LEAD_FALL;
                    end else begin
                        fail_q = FAIL_LEAD_MARK;
                        drop_frame();
                    end
                end
                PH_BIT_RISE: begin
                    if (in_window(d, BIT_MARK_MIN, BIT_MARK_MAX)) begin
                        rx_ph = PH_BIT_FALL;
                    end else begin
                        fail_q = FAIL_BIT_MARK;
                        drop_frame();
                    end
                end
                PH_IDLE: ;
                default: begin
                    fail_q = FAIL_STRAY_EDGE;
                    drop_frame();
                end
            endcase
        end
    endtask

    // Expected result of one item beat.
    task automatic decode_item(input logic op, input logic [15:0] t, input logic lvl,
                               input logic [31:0] now, output t_result r);
        logic        applied;
        logic [31:0] age;
        applied = 1'b0;
        if (op == OP_EDGE) take_edge(t, lvl, now, applied);
        age             = now - key_ms;
        r.motion_cmd    = (age < {16'd0, cfg_q.hold_time_ms}) ? held_q : MOTION_STOP;
        r.key_applied   = applied;
        r.last_code     = code_q;
        r.fail_code     = fail_q;
        r.edge_total    = edges_q;
        r.lead_mark_us  = mark_q;
        r.lead_space_us = space_q;
    endtask

    // Compare result beats, track register writes, predict item beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_q     = '{HOLD_TIME_RST, FRAME_GAP_RST, LEAD_MARK_MIN_RST, LEAD_MARK_MAX_RST};
            drop_frame();
            last_edge = '0;
            code_q    = '0;
            held_q    = MOTION_STOP;
            key_ms    = '0;
            edges_q   = '0;
            mark_q    = '0;
            space_q   = '0;
            fail_q    = FAIL_OK;
            pending_results.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with no item waiting for it");
                end else begin
                    want = pending_results.pop_front();
                    check_field("motion_cmd", 32'(i_out_data[2:0]), 32'(want.motion_cmd));
                    check_field("key_applied", 32'(i_out_data[3]), 32'(want.key_applied));
                    check_field("last_code", 32'(i_out_data[11:4]), 32'(want.last_code));
                    check_field("fail_code", 32'(i_out_data[15:12]), 32'(want.fail_code));
                    check_field("edge_total", i_out_data[47:16], want.edge_total);
                    check_field("lead_mark_us", 32'(i_out_data[63:48]),
                                32'(want.lead_mark_us));
                    check_field("lead_space_us", 32'(i_out_data[79:64]),
                                32'(want.lead_space_us));
                end
                result_idx++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_HOLD_TIME:     cfg_q.hold_time_ms     = i_cfg_data;
                    REG_FRAME_GAP:     cfg_q.frame_gap_us     = i_cfg_data;
                    REG_LEAD_MARK_MIN: cfg_q.lead_mark_min_us = i_cfg_data;
                    REG_LEAD_MARK_MAX: cfg_q.lead_mark_max_us = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                decode_item(i_in_user[0], i_in_data[15:0], i_in_data[16],
                            i_in_data[48:17], fresh);
                pending_results.push_back(fresh);
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

// ===== verif/nec_ir_edge_decoder_tb.sv =====
// Stimulus and verdict for the IR decoder: timed NEC frames, repeats, broken
// frames, ticks and noise under several register settings.
module nec_ir_edge_decoder_tb;
    import nirdec_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 29;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    t_reg_idx               i_cfg_index = REG_HOLD_TIME;
    logic [15:0]            i_cfg_data = '0;

    int          pending;
    int          errors;
    int          cycle_count = 0;
    logic        calm = 1'b0;
    logic        stall_req = 1'b0;
    logic        stall_ack = 1'b0;
    int          stall_left = 0;

    // Stimulus time base and current register copy.
    logic [15:0] us_now = '0;
    logic [31:0] ms_now = '0;
    int          edge_idx = 0;
    int          spoil_at = -1;
    int          items_sent = 0;
    logic [15:0] cur_hold = HOLD_TIME_RST;
    logic [15:0] cur_gap  = FRAME_GAP_RST;
    logic [15:0] cur_min  = LEAD_MARK_MIN_RST;
    logic [15:0] cur_max  = LEAD_MARK_MAX_RST;

    nec_ir_edge_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    nec_ir_edge_decoder_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (stall_req != stall_ack) begin
            stall_ack     <= stall_req;
            stall_left    <= STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Offers one item beat after a random gap and waits until it is taken.
    task automatic send_item(input logic op, input logic [15:0] t, input logic lvl,
                             input logic [31:0] now);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, now, lvl, t};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Stops offering items and lets every expected result come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    function automatic logic [15:0] pick(input logic [15:0] lo, input logic [15:0] hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return 16'($urandom_range(lo, hi));
    endfunction

    function automatic logic [7:0] mirror(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

    // One receiver edge after dur microseconds; a spoiled edge gets a wrong
    // level or a random length.
    task automatic emit(input logic [15:0] dur, input logic lvl);
        logic [15:0] d;
        logic        l;
        d = dur;
        l = lvl;
        if (edge_idx == spoil_at) begin
            if ($urandom_range(0, 1)) l = ~l;
            else d = 16'($urandom_range(0, 65535));
        end
        edge_idx++;
        us_now = us_now + d;
        ms_now = ms_now + (d >> 10);
        send_item(OP_EDGE, us_now, l, ms_now);
    endtask

    // Falling edge that opens the leader, then the leader mark.
    task automatic lead_in();
        logic [15:0] gap;
        if ($urandom_range(0, 1) && cur_gap < 16'hFFFF) begin
            gap = 16'($urandom_range((cur_gap < IDLE_ARM_GAP) ? IDLE_ARM_GAP + 1
                                                               : cur_gap + 1,
                                     65535));
        end else begin
            gap = 16'($urandom_range(IDLE_ARM_GAP + 1, 12000));
        end
        emit(gap, 1'b0);
        if ($urandom_range(0, 3) == 0 || cur_min > cur_max) begin
            emit(pick(SHORT_LEAD_MIN, SHORT_LEAD_MAX), 1'b1);
        end else begin
            emit(pick(cur_min, cur_max), 1'b1);
        end
    endtask

    // Full data frame with random content; spoil picks an edge to break.
    task automatic send_frame(input int spoil);
        logic [7:0]  addr;
        logic [7:0]  addr_cpl;
        logic [7:0]  cmd;
        logic [7:0]  cmd_inv;
        logic [7:0]  key;
        logic [31:0] word;
        case ($urandom_range(0, 4))
            0: key = KEY_UP;
            1: key = KEY_DOWN;
            2: key = KEY_LEFT;
            3: key = KEY_RIGHT;
            default: key = KEY_OK;
        endcase
        addr     = 8'($urandom);
        addr_cpl = ~addr;
        cmd      = key;
        cmd_inv  = ~key;
        case ($urandom_range(0, 9))
            4: begin
                cmd     = mirror(key);
                cmd_inv = ~cmd;
            end
            5: begin
                cmd     = 8'($urandom);
                cmd_inv = key;
            end
            6: begin
                cmd     = 8'($urandom);
                cmd_inv = mirror(key);
            end
            7: begin
                addr_cpl = 8'($urandom);
                cmd      = 8'($urandom);
                cmd_inv  = 8'($urandom);
            end
            8: begin
                cmd     = 8'($urandom);
                cmd_inv = ~cmd;
            end
            9: begin
                cmd     = 8'($urandom);
                cmd_inv = 8'($urandom);
            end
            default: ;
        endcase
        word     = {cmd_inv, cmd, addr_cpl, addr};
        spoil_at = spoil;
        edge_idx = 0;
        lead_in();
        emit(pick(DATA_SPACE_MIN + 1, DATA_SPACE_MAX), 1'b0);
        for (int i = 0; i < 32; i++) begin
            emit(pick(BIT_MARK_MIN, BIT_MARK_MAX), 1'b1);
            emit(word[i] ? pick(ONE_SPACE_MIN, ONE_SPACE_MAX)
                         : pick(ZERO_SPACE_MIN, ZERO_SPACE_MAX), 1'b0);
        end
        emit(pick(BIT_MARK_MIN, BIT_MARK_MAX), 1'b1);
        spoil_at = -1;
    endtask

    // One randomly chosen sequence: mostly frames and repeats.
    task automatic one_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            send_frame(-1);
        end else if (r < 70) begin
            lead_in();
            emit(pick(REPEAT_MIN, REPEAT_MAX), 1'b0);
            emit(pick(BIT_MARK_MIN, BIT_MARK_MAX), 1'b1);
        end else if (r < 80) begin
            send_frame($urandom_range(0, 67));
        end else if (r < 90) begin
            ms_now = ms_now + $urandom_range(0, 2 * int'(cur_hold));
            send_item(OP_TICK, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                      ms_now);
        end else begin
            repeat ($urandom_range(1, 3)) begin
                send_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)), $urandom);
            end
        end
    endtask

    // New register setting while idle, then random sequences up to a budget.
    task automatic run_phase(input logic [15:0] hold, input logic [15:0] gap,
                             input logic [15:0] lo, input logic [15:0] hi,
                             input int budget, input bit hold_off);
        int target;
        drain_results();
        write_reg(REG_HOLD_TIME, hold);
        write_reg(REG_FRAME_GAP, gap);
        write_reg(REG_LEAD_MARK_MIN, lo);
        write_reg(REG_LEAD_MARK_MAX, hi);
        i_cfg_valid <= 1'b0;
        cur_hold = hold;
        cur_gap  = gap;
        cur_min  = lo;
        cur_max  = hi;
        if (hold_off) stall_req <= ~stall_req;
        target = items_sent + budget;
        while (items_sent < target) one_sequence();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset setting.
        send_item(OP_TICK, 16'h0000, 1'b0, 32'h0000_0000);
        send_item(OP_TICK, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        emit(16'd500, 1'b1);     // rising edge in idle is ignored
        emit(16'd100, 1'b0);     // falling edge too soon to arm
        emit(16'd3000, 1'b0);    // exactly the arm gap, still idle
        emit(16'd3001, 1'b0);    // arms the leader
        emit(16'd500, 1'b0);     // second falling edge is a stray edge
        emit(16'd20000, 1'b0);   // long gap resets, then arms
        emit(16'd5000, 1'b1);    // leader mark out of both windows
        emit(16'd4000, 1'b0);
        emit(16'd200, 1'b1);     // short leader mark
        emit(16'd1200, 1'b0);    // repeat with no saved code
        emit(16'd4000, 1'b0);
        emit(16'd6800, 1'b1);
        emit(16'd7000, 1'b0);    // bad leader space
        emit(16'd3500, 1'b0);
        emit(16'd11200, 1'b1);
        emit(16'd3201, 1'b0);    // data space
        emit(16'd100, 1'b1);     // bit mark too short
        emit(16'd3500, 1'b0);
        emit(16'd1200, 1'b1);
        emit(16'd6200, 1'b0);
        emit(16'd150, 1'b1);
        emit(16'd1050, 1'b0);    // bit space between the zero and one windows
        emit(16'hFFFF, 1'b1);

        // Random part across several settings.
        run_phase(HOLD_TIME_RST, FRAME_GAP_RST, LEAD_MARK_MIN_RST, LEAD_MARK_MAX_RST,
                  350, 1'b0);
        run_phase(16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 400, 1'b1);
        run_phase(16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 60, 1'b0);
        calm   <= 1'b1;
        ms_now = 32'hFFFF_F000;
        run_phase(16'd2000, 16'd20000, 16'd9000, 16'd9000, 400, 1'b0);
        drain_results();
        calm <= 1'b0;
        run_phase(16'($urandom_range(1, 3000)), 16'($urandom_range(8000, 40000)),
                  16'($urandom_range(4000, 9000)), 16'($urandom_range(9000, 13000)),
                  400, 1'b0);
        drain_results();

        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
